>>> sv/bcc_pkg.sv
`default_nettype none

package bcc_pkg;

  localparam int unsigned WORDS_DEF   = 1024;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned OFF_W       = 6;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned WIDX_W      = 10;
  localparam int unsigned TOTAL_W     = 17;
  localparam int unsigned DISTINCT_W  = 17;
  localparam int unsigned COVERED_W   = 32;
  localparam int unsigned COAL_W      = 16;
  localparam int unsigned CADD_W      = 16;
  localparam int unsigned REQ_W       = 3;

  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned IN_TUSER_W  = 4;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 17;

  localparam logic [WORD_W-1:0]   EVEN_BITS   = 64'h5555_5555_5555_5555;
  localparam logic [TOTAL_W-1:0]  TOTAL_RESET = 17'd65536;

  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_MERGE    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_OVERLAP  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CONTAINS = 3'd4;
  localparam logic [REQ_W-1:0] REQ_MARK     = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COAL  = 2'd1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [SAMPLE_W-1:0] sample_index;
    logic [WIDX_W-1:0]   word_index;
    logic [WORD_W-1:0]   word_value;
    logic                track_coal;
    logic [CADD_W-1:0]   covered_add;
  } item_t;

  typedef struct packed {
    logic [DISTINCT_W-1:0] distinct;
    logic [COVERED_W-1:0]  covered;
    logic [COAL_W-1:0]     coal;
  } counts_t;

  typedef struct packed {
    logic                set_we;
    logic [WORD_W-1:0]   set_wdata;
    logic                seen_we;
    logic [WORD_W-1:0]   seen_wdata;
    logic                clr;
    logic                hit;
    logic                err;
    counts_t             counts;
  } upd_t;

  // word of the memories that an item touches
  function automatic logic [WIDX_W-1:0] item_word(item_t it);
    logic [WIDX_W-1:0] w;
    if (it.req_type == REQ_MERGE || it.req_type == REQ_OVERLAP) begin
      w = it.word_index;
    end else begin
      w = it.sample_index[SAMPLE_W-1:OFF_W];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

>>> sv/bitset_coverage_coalescence.sv
// A result word is registered in the cycle after its input word is accepted.
// No new item is taken until the last one has done its read and write-back of one
// word of the coverage and seen memories, nor while an untaken result is held.
// Reset and clear both start a sweep of all WORDS words, zeroing both memories;
// no input word is taken during the sweep. Config writes are taken at any time.
// Counters reset to zero, total_samples to 65536 and coal_enable to one.
`default_nettype none

module bitset_coverage_coalescence #(
  parameter int unsigned WORDS = bcc_pkg::WORDS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // tdata: sample_index[15:0], word_index[25:16], word_value[89:26],
  //        covered_add[105:90], zero pad
  input  wire logic [bcc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: req_type[2:0], track_coal[3]
  input  wire logic [bcc_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: hit[0], distinct_count[17:1], covered_count[49:18],
  //        coal_count[65:50], error[66], zero pad
  output logic      [bcc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bcc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [bcc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import bcc_pkg::*;

  localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  state_e              state_q, state_d;
  logic [AW-1:0]       sweep_q, sweep_d;
  item_t               item_q, item_in;
  counts_t             counts_q, counts_d;
  logic [TOTAL_W-1:0]  total_q;
  logic                coal_en_q;
  logic                out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                in_acc;
  logic                sweeping;
  logic                exec;
  upd_t                upd;

  logic                mem_we;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [WORD_W-1:0]   set_wdata, seen_wdata;
  logic [WORD_W-1:0]   set_rdata, seen_rdata;
  logic                set_we, seen_we;

  assign item_in.sample_index = s_axis_tdata[15:0];
  assign item_in.word_index   = s_axis_tdata[25:16];
  assign item_in.word_value   = s_axis_tdata[89:26];
  assign item_in.covered_add  = s_axis_tdata[105:90];
  assign item_in.req_type     = s_axis_tuser[2:0];
  assign item_in.track_coal   = s_axis_tuser[3];

  assign sweeping      = (state_q == ST_CLEAR);
  assign exec          = (state_q == ST_EXEC);
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    unique case (state_q)
      ST_CLEAR: begin
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == LAST_WORD) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (upd.clr) begin
          state_d = ST_CLEAR;
          sweep_d = '0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        sweep_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= item_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= TOTAL_RESET;
      coal_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TOTAL: total_q   <= cfg_data_i[TOTAL_W-1:0];
        CFG_COAL:  coal_en_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign raddr      = AW'(item_word(item_in));
  assign waddr      = sweeping ? sweep_q : AW'(item_word(item_q));
  assign mem_we     = sweeping;
  assign set_we     = mem_we || (exec && upd.set_we);
  assign seen_we    = mem_we || (exec && upd.seen_we);
  assign set_wdata  = sweeping ? '0 : upd.set_wdata;
  assign seen_wdata = sweeping ? '0 : upd.seen_wdata;

  bcc_ram #(.DEPTH(WORDS), .AW(AW)) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (set_we),
    .waddr_i (waddr),
    .wdata_i (set_wdata),
    .re_i    (in_acc),
    .raddr_i (raddr),
    .rdata_o (set_rdata)
  );

  bcc_ram #(.DEPTH(WORDS), .AW(AW)) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (seen_we),
    .waddr_i (waddr),
    .wdata_i (seen_wdata),
    .re_i    (in_acc),
    .raddr_i (raddr),
    .rdata_o (seen_rdata)
  );

  bcc_update #(.WORDS(WORDS)) u_update (
    .item_i     (item_q),
    .cur_set_i  (set_rdata),
    .cur_seen_i (seen_rdata),
    .counts_i   (counts_q),
    .total_i    (total_q),
    .coal_en_i  (coal_en_q),
    .upd_o      (upd)
  );

  assign counts_d = exec ? upd.counts : counts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q <= '0;
    end else begin
      counts_q <= counts_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_data_q <= {5'd0, upd.err, upd.counts.coal, upd.counts.covered,
                     upd.counts.distinct, upd.hit};
    end
  end

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tvalid = out_valid_q;

  // no word is taken while the memories are being zeroed
  a_no_accept_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweeping |-> !s_axis_tready)
    else $error("input accepted during sweep");

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_EXEC))
    else $error("accepted word not executed");

  a_exec_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |-> !out_valid_q)
    else $error("result register busy at execute");

  a_exec_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> m_axis_tvalid)
    else $error("execute did not produce a result");

  a_sweep_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sweeping && sweep_q == LAST_WORD) |=> (state_q == ST_IDLE))
    else $error("sweep did not end");

endmodule

`default_nettype wire

>>> sv/bcc_ram.sv
`default_nettype none

module bcc_ram #(
  parameter int unsigned DEPTH = bcc_pkg::WORDS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [bcc_pkg::WORD_W-1:0]  wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output logic      [bcc_pkg::WORD_W-1:0]  rdata_o
);
  import bcc_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/bcc_update.sv
`default_nettype none

module bcc_update #(
  parameter int unsigned WORDS = bcc_pkg::WORDS_DEF
) (
  input  wire bcc_pkg::item_t                    item_i,
  input  wire logic [bcc_pkg::WORD_W-1:0]        cur_set_i,
  input  wire logic [bcc_pkg::WORD_W-1:0]        cur_seen_i,
  input  wire bcc_pkg::counts_t                  counts_i,
  input  wire logic [bcc_pkg::TOTAL_W-1:0]       total_i,
  input  wire logic                              coal_en_i,
  output bcc_pkg::upd_t                          upd_o
);
  import bcc_pkg::*;

  function automatic logic [6:0] pop64(logic [WORD_W-1:0] x);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

  logic [WIDX_W-1:0]     s_word;
  logic [OFF_W-1:0]      s_off;
  logic                  samp_ok;
  logic [SAMPLE_W-1:0]   base;
  logic [TOTAL_W-1:0]    rem;
  logic                  wrd_ok;
  logic [WORD_W-1:0]     mask;
  logic [WORD_W-1:0]     v;
  logic [WORD_W-1:0]     folded;
  logic [WORD_W-1:0]     bit_m;
  logic [WORD_W-1:0]     pair_m;
  logic                  track;
  logic [6:0]            pop_new;
  logic [6:0]            pop_coal;
  logic [DISTINCT_W:0]   dsum;
  logic [COVERED_W:0]    csum;
  logic [COAL_W:0]       ksum;

  always_comb begin
    s_word  = item_i.sample_index[SAMPLE_W-1:OFF_W];
    s_off   = item_i.sample_index[OFF_W-1:0];
    samp_ok = ({1'b0, item_i.sample_index} < total_i) && (32'(s_word) < 32'(WORDS));

    base   = {item_i.word_index, {OFF_W{1'b0}}};
    wrd_ok = (32'(item_i.word_index) < 32'(WORDS)) && ({1'b0, base} < total_i);
    rem    = total_i - {1'b0, base};
    if (!wrd_ok) begin
      mask = '0;
    end else if (rem >= TOTAL_W'(WORD_W)) begin
      mask = '1;
    end else begin
      mask = ~({WORD_W{1'b1}} << rem[OFF_W-1:0]);
    end

    v        = item_i.word_value & mask;
    folded   = (v | (v >> 1)) & EVEN_BITS;
    bit_m    = WORD_W'(1) << s_off;
    pair_m   = WORD_W'(1) << {s_off[OFF_W-1:1], 1'b0};
    track    = item_i.track_coal & coal_en_i;
    pop_new  = pop64(v & ~cur_set_i);
    pop_coal = pop64(folded & cur_seen_i);

    upd_o            = '0;
    upd_o.set_wdata  = cur_set_i;
    upd_o.seen_wdata = cur_seen_i;
    upd_o.counts     = counts_i;
    dsum = {1'b0, counts_i.distinct};
    csum = {1'b0, counts_i.covered};
    ksum = {1'b0, counts_i.coal};

    unique case (item_i.req_type) inside
      REQ_CLEAR: begin
        upd_o.clr    = 1'b1;
        upd_o.counts = '0;
      end
      REQ_ADD, REQ_CONTAINS, REQ_MARK: begin
        if (!samp_ok) begin
          upd_o.err = 1'b1;
        end else if (item_i.req_type == REQ_ADD) begin
          csum = csum + (COVERED_W+1)'(1);
          if ((cur_set_i & bit_m) == '0) dsum = dsum + (DISTINCT_W+1)'(1);
          upd_o.set_we    = 1'b1;
          upd_o.set_wdata = cur_set_i | bit_m;
        end else if (item_i.req_type == REQ_CONTAINS) begin
          upd_o.hit = |(cur_set_i & bit_m);
        end else if (coal_en_i) begin
          if ((cur_seen_i & pair_m) != '0) ksum = ksum + (COAL_W+1)'(1);
          upd_o.seen_we    = 1'b1;
          upd_o.seen_wdata = cur_seen_i | pair_m;
        end
      end
      REQ_MERGE, REQ_OVERLAP: begin
        if (!wrd_ok) begin
          upd_o.err = 1'b1;
        end else if (item_i.req_type == REQ_OVERLAP) begin
          upd_o.hit = |(cur_set_i & v);
        end else begin
          csum = csum + (COVERED_W+1)'(item_i.covered_add);
          dsum = dsum + (DISTINCT_W+1)'(pop_new);
          upd_o.set_we    = 1'b1;
          upd_o.set_wdata = cur_set_i | v;
          if (track) begin
            ksum = ksum + (COAL_W+1)'(pop_coal);
            upd_o.seen_we    = 1'b1;
            upd_o.seen_wdata = cur_seen_i | folded;
          end
        end
      end
      default: begin
      end
    endcase

    if (!upd_o.clr) begin
      upd_o.counts.distinct = dsum[DISTINCT_W] ? '1 : dsum[DISTINCT_W-1:0];
      upd_o.counts.covered  = csum[COVERED_W]  ? '1 : csum[COVERED_W-1:0];
      upd_o.counts.coal     = ksum[COAL_W]     ? '1 : ksum[COAL_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_bitset_coverage_coalescence.sv
`timescale 1ns / 100ps

module tb_bitset_coverage_coalescence;
  import bcc_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_B = 3'd7;
  localparam int unsigned      MAP_WORDS    = WORDS_DEF;
  localparam int unsigned      DISTINCT_SAT = 32'h1_FFFF;
  localparam int unsigned      COAL_SAT     = 32'hFFFF;
  localparam int               HOLD_CYCLES  = 300;
  localparam int               NUM_PHASES   = 7;

  typedef struct packed {
    logic                  hit;
    logic [DISTINCT_W-1:0] distinct_count;
    logic [COVERED_W-1:0]  covered_count;
    logic [COAL_W-1:0]     coal_count;
    logic                  err_flag;
  } result_t;

  class coverage_tracker;
    bit [WORD_W-1:0]  cov_map[MAP_WORDS];
    bit [WORD_W-1:0]  seen_map[MAP_WORDS];
    int unsigned      total_samples;
    bit               coal_en;
    int unsigned      distinct_total;
    longint unsigned  covered_total;
    int unsigned      coal_total;
    result_t          expected_q[$];
    int               fails;

    function new();
      total_samples = 65536;
      coal_en = 1'b1;
      fails = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (cov_map[i]) begin
        cov_map[i] = '0;
        seen_map[i] = '0;
      end
      distinct_total = 0;
      covered_total = 0;
      coal_total = 0;
    endfunction

    function void set_total(int unsigned v);
      total_samples = v;
    endfunction

    function void set_coal(bit v);
      coal_en = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // bits of word w below total_samples; zero if the word is out of range
    function bit [WORD_W-1:0] word_mask(int unsigned w);
      int unsigned base;
      int unsigned rem;
      base = w * WORD_W;
      if (w >= MAP_WORDS || base >= total_samples) return '0;
      rem = total_samples - base;
      if (rem >= WORD_W) return '1;
      return (64'd1 << rem) - 64'd1;
    endfunction

    function void bump_distinct(int unsigned n);
      distinct_total = (distinct_total + n > DISTINCT_SAT) ? DISTINCT_SAT : distinct_total + n;
    endfunction

    function void bump_covered(longint unsigned n);
      covered_total = (covered_total + n > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : covered_total + n;
    endfunction

    function void bump_coal(int unsigned n);
      coal_total = (coal_total + n > COAL_SAT) ? COAL_SAT : coal_total + n;
    endfunction

    function void note_item(logic [REQ_W-1:0] req, logic [SAMPLE_W-1:0] smp,
                            logic [WIDX_W-1:0] widx, logic [WORD_W-1:0] wval,
                            logic trk, logic [CADD_W-1:0] cadd);
      result_t         r;
      bit [WORD_W-1:0] cur;
      bit [WORD_W-1:0] m;
      bit [WORD_W-1:0] v;
      bit [WORD_W-1:0] folded;
      int unsigned     w;
      int unsigned     off;
      r = '0;
      case (req) inside
        REQ_CLEAR: begin
          wipe();
        end
        REQ_ADD, REQ_CONTAINS, REQ_MARK: begin
          if (int'(smp) >= int'(total_samples)) begin
            r.err_flag = 1'b1;
          end else begin
            w = smp[SAMPLE_W-1:OFF_W];
            off = smp[OFF_W-1:0];
            cur = cov_map[w];
            if (req == REQ_ADD) begin
              bump_covered(1);
              if (!cur[off]) bump_distinct(1);
              cov_map[w] = cur | (64'd1 << off);
            end else if (req == REQ_CONTAINS) begin
              r.hit = cur[off];
            end else if (coal_en) begin
              m = 64'd1 << {off[5:1], 1'b0};
              if ((seen_map[w] & m) != 0) bump_coal(1);
              seen_map[w] = seen_map[w] | m;
            end
          end
        end
        REQ_MERGE, REQ_OVERLAP: begin
          m = word_mask(widx);
          if (m == 0) begin
            r.err_flag = 1'b1;
          end else begin
            w = widx;
            v = wval & m;
            cur = cov_map[w];
            if (req == REQ_OVERLAP) begin
              r.hit = ((cur & v) != 0);
            end else begin
              bump_covered(cadd);
              bump_distinct($countones(v & ~cur));
              cov_map[w] = cur | v;
              if (trk && coal_en) begin
                folded = (v | (v >> 1)) & EVEN_BITS;
                bump_coal($countones(folded & seen_map[w]));
                seen_map[w] = seen_map[w] | folded;
              end
            end
          end
        end
        default: ;
      endcase
      r.distinct_count = distinct_total[DISTINCT_W-1:0];
      r.covered_count = covered_total[COVERED_W-1:0];
      r.coal_count = coal_total[COAL_W-1:0];
      expected_q = {expected_q, r};
    endfunction

    task report(string msg);
      fails++;
      if (fails <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] td);
      result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result word %h", td));
      end else begin
        e = expected_q.pop_front();
        if (td[0] !== e.hit)
          report($sformatf("hit %b, want %b", td[0], e.hit));
        if (td[17:1] !== e.distinct_count)
          report($sformatf("distinct %0d, want %0d", td[17:1], e.distinct_count));
        if (td[49:18] !== e.covered_count)
          report($sformatf("covered %0d, want %0d", td[49:18], e.covered_count));
        if (td[65:50] !== e.coal_count)
          report($sformatf("coal %0d, want %0d", td[65:50], e.coal_count));
        if (td[66] !== e.err_flag)
          report($sformatf("error %b, want %b", td[66], e.err_flag));
      end
    endtask

    task flush_check();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]   s_axis_tuser = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  coverage_tracker sb = new();

  int tx_gap_pct = 28;
  int rx_stall_pct = 63;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int unsigned ph_total[NUM_PHASES] = '{65536, 1000, 1, 448, 0, 65536, 3001};
  bit          ph_coal[NUM_PHASES]  = '{1, 0, 1, 1, 1, 1, 1};
  int          ph_gap[NUM_PHASES]   = '{28, 28, 63, 63, 63, 0, 0};
  int          ph_stall[NUM_PHASES] = '{63, 63, 28, 28, 28, 0, 0};
  int          ph_items[NUM_PHASES] = '{380, 300, 120, 300, 40, 380, 330};

  bitset_coverage_coalescence u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, plus a long hold on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin
    #15000000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_item(input logic [REQ_W-1:0] req, input logic [SAMPLE_W-1:0] smp,
                           input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] wval,
                           input logic trk, input logic [CADD_W-1:0] cadd);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, cadd, wval, widx, smp};
    s_axis_tuser <= {trk, req};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(req, smp, widx, wval, trk, cadd);
  endtask

  task automatic write_cfg(input int unsigned total, input bit coal);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_TOTAL;
    cfg_data_i <= total[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_total(total);
    cfg_index_i <= CFG_COAL;
    cfg_data_i <= {{(CFG_DATA_W-1){1'b0}}, coal};
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_coal(coal);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(int unsigned total);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (total == 0 || r < 15) return SAMPLE_W'($urandom_range(0, 65535));
    if (r < 60) return SAMPLE_W'($urandom_range(0, (total < 256 ? total : 256) - 1));
    return SAMPLE_W'($urandom_range(0, total - 1));
  endfunction

  function automatic logic [WIDX_W-1:0] pick_word(int unsigned total);
    int unsigned r;
    int unsigned last;
    r = $urandom_range(0, 99);
    if (total == 0 || r < 15) return WIDX_W'($urandom_range(0, 1023));
    last = (total - 1) / WORD_W;
    if (r < 55) return WIDX_W'($urandom_range(0, last < 3 ? last : 3));
    if (r < 70) return WIDX_W'(last);
    return WIDX_W'($urandom_range(0, last));
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return 64'd1 << $urandom_range(0, 63);
      5: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random();
    int unsigned         r;
    logic [REQ_W-1:0]    req;
    logic [CADD_W-1:0]   cadd;
    r = $urandom_range(0, 99);
    if (r < 2) req = REQ_CLEAR;
    else if (r < 22) req = REQ_ADD;
    else if (r < 47) req = REQ_MERGE;
    else if (r < 62) req = REQ_OVERLAP;
    else if (r < 80) req = REQ_CONTAINS;
    else if (r < 95) req = REQ_MARK;
    else req = $urandom_range(0, 1) ? REQ_UNUSED_A : REQ_UNUSED_B;
    r = $urandom_range(0, 99);
    cadd = (r < 10) ? 16'hFFFF : (r < 20) ? 16'h0 : 16'($urandom_range(0, 65535));
    send_item(req, pick_sample(sb.total_samples), pick_word(sb.total_samples), pick_value(),
              ($urandom_range(0, 9) < 7), cadd);
  endtask

  initial begin
    int cnt;
    int p;
    int k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: 65536 samples, tracking on
    send_item(REQ_CONTAINS, 16'd0, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_ADD, 16'd0, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_ADD, 16'd0, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_ADD, 16'hFFFF, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_CONTAINS, 16'hFFFF, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_CONTAINS, 16'd1, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_MERGE, 16'd0, 10'd0, '1, 1'b1, 16'hFFFF);
    send_item(REQ_MERGE, 16'd0, 10'd0, '1, 1'b1, 16'd1);
    send_item(REQ_MERGE, 16'd0, 10'd1023, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 16'd0);
    send_item(REQ_OVERLAP, 16'd0, 10'd1023, 64'h5555_5555_5555_5555, 1'b0, 16'd0);
    send_item(REQ_OVERLAP, 16'd0, 10'd1023, '1, 1'b0, 16'd0);
    send_item(REQ_MARK, 16'd1, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_MARK, 16'd200, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_MARK, 16'd201, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_UNUSED_A, 16'hFFFF, 10'd1023, '1, 1'b1, 16'hFFFF);
    send_item(REQ_UNUSED_B, 16'd5, 10'd5, 64'd5, 1'b0, 16'd5);
    send_item(REQ_CLEAR, 16'd0, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_CONTAINS, 16'd0, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_MERGE, 16'd0, 10'd5, 64'd0, 1'b1, 16'd1);
    s_axis_tvalid <= 1'b0;
    drain();
    repeat (4) @(posedge clk_i);

    // partial last word, tracking disabled
    write_cfg(100, 1'b0);
    send_item(REQ_ADD, 16'd100, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_ADD, 16'd99, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_MERGE, 16'd0, 10'd1, '1, 1'b1, 16'd7);
    send_item(REQ_OVERLAP, 16'd0, 10'd2, '1, 1'b0, 16'd0);
    send_item(REQ_MARK, 16'd5, 10'd0, 64'd0, 1'b0, 16'd0);
    send_item(REQ_CONTAINS, 16'd99, 10'd0, 64'd0, 1'b0, 16'd0);

    for (p = 0; p < NUM_PHASES; p++) begin
      s_axis_tvalid <= 1'b0;
      drain();
      repeat (4) @(posedge clk_i);
      write_cfg(ph_total[p], ph_coal[p]);
      tx_gap_pct = ph_gap[p];
      rx_stall_pct = ph_stall[p];
      for (k = 0; k < ph_items[p]; k++) begin
        if (p == 5 && k == 100) hold_req = hold_req + 1;
        if (p == 5 && k == 260) begin
          s_axis_tvalid <= 1'b0;
          drain();
        end
        send_random();
      end
    end

    s_axis_tvalid <= 1'b0;
    cnt = 0;
    while (sb.pending() != 0 && cnt < 5000) begin
      @(posedge clk_i);
      cnt++;
    end
    repeat (8) @(posedge clk_i);
    sb.flush_check();
    if (sb.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
